>>> design/pcc_pkg.sv
// Shared types and constants of the clamped PID controller.
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int DataWidth    = 16;
  localparam int GainWidth    = 16;
  localparam int FracBits     = 8;
  localparam int IntWidth     = 32;
  localparam int DerivWidth   = DataWidth + 1;
  localparam int PropWidth    = GainWidth + DataWidth;
  localparam int IntgWidth    = GainWidth + IntWidth;
  localparam int DerWidth     = GainWidth + DerivWidth;
  localparam int AccWidth     = IntgWidth + 2;
  localparam int ShWidth      = AccWidth - FracBits;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 16;
  localparam int MidDepth     = 2;
  localparam int OutDepth     = 4;
  localparam int OutPtrWidth  = $clog2(OutDepth);
  localparam int OutCntWidth  = $clog2(OutDepth + 1);
  localparam int CreditWidth  = OutCntWidth + 1;

  localparam logic [CfgIdxWidth-1:0] RegSetpoint = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegGainP    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegGainI    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegGainD    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegOutMin   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegOutMax   = 3'd5;

  typedef struct packed {
    logic signed [DataWidth-1:0]  setpoint;
    logic signed [GainWidth-1:0]  gain_p;
    logic signed [GainWidth-1:0]  gain_i;
    logic signed [GainWidth-1:0]  gain_d;
    logic signed [DataWidth-1:0]  out_min;
    logic signed [DataWidth-1:0]  out_max;
  } cfg_t;

  typedef struct packed {
    logic signed [DataWidth-1:0]  err;
    logic signed [DerivWidth-1:0] deriv;
    logic signed [IntWidth-1:0]   integ;
  } work_t;

endpackage

>>> design/pcc_front.sv
// Front end: error, derivative and saturating integral update per sample.
`timescale 1ns / 1ps

module pcc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic signed [pcc_pkg::DataWidth-1:0] measurement_i,
  input  logic signed [pcc_pkg::DataWidth-1:0] setpoint_i,
  input  logic                                q_full_i,
  output logic                                wr_o,
  output pcc_pkg::work_t                      word_o
);

  logic signed [pcc_pkg::DataWidth-1:0]  prev_q, prev_d;
  logic signed [pcc_pkg::IntWidth-1:0]   integ_q, integ_d;
  logic signed [pcc_pkg::DataWidth:0]    diff;
  logic signed [pcc_pkg::DataWidth-1:0]  err;
  logic signed [pcc_pkg::DerivWidth-1:0] deriv;
  logic signed [pcc_pkg::IntWidth:0]     sum;
  logic signed [pcc_pkg::IntWidth-1:0]   integ_new;
  logic                                  accept;

  assign accept = push_i && !q_full_i;

  always_comb begin
    diff = {setpoint_i[pcc_pkg::DataWidth-1], setpoint_i}
         - {measurement_i[pcc_pkg::DataWidth-1], measurement_i};
    if (diff[pcc_pkg::DataWidth] != diff[pcc_pkg::DataWidth-1]) begin
      err = {diff[pcc_pkg::DataWidth], {(pcc_pkg::DataWidth-1){~diff[pcc_pkg::DataWidth]}}};
    end else begin
      err = diff[pcc_pkg::DataWidth-1:0];
    end
    deriv = {measurement_i[pcc_pkg::DataWidth-1], measurement_i}
          - {prev_q[pcc_pkg::DataWidth-1], prev_q};
    sum = {integ_q[pcc_pkg::IntWidth-1], integ_q}
        + {{(pcc_pkg::IntWidth+1-pcc_pkg::DataWidth){err[pcc_pkg::DataWidth-1]}}, err};
    if (sum[pcc_pkg::IntWidth] != sum[pcc_pkg::IntWidth-1]) begin
      integ_new = {sum[pcc_pkg::IntWidth], {(pcc_pkg::IntWidth-1){~sum[pcc_pkg::IntWidth]}}};
    end else begin
      integ_new = sum[pcc_pkg::IntWidth-1:0];
    end
    prev_d  = accept ? measurement_i : prev_q;
    integ_d = accept ? integ_new : integ_q;
  end

  assign wr_o         = accept;
  assign word_o.err   = err;
  assign word_o.deriv = deriv;
  assign word_o.integ = integ_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else begin
      prev_q  <= prev_d;
      integ_q <= integ_d;
    end
  end

endmodule

>>> design/pcc_mid_q.sv
// Two-entry queue between the front end and the multiply back end.
`timescale 1ns / 1ps

module pcc_mid_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  pcc_pkg::work_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           empty_o,
  output pcc_pkg::work_t rdata_o
);

  localparam int PtrWidth = $clog2(pcc_pkg::MidDepth);
  localparam int CntWidth = $clog2(pcc_pkg::MidDepth + 1);

  pcc_pkg::work_t        mem_q [pcc_pkg::MidDepth];
  logic [PtrWidth-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntWidth'(pcc_pkg::MidDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wr_i ? PtrWidth'(wptr_q + 1'b1) : wptr_q;
    rptr_d = rd_i ? PtrWidth'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q + CntWidth'(wr_i) - CntWidth'(rd_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> design/pcc_back.sv
// Back end: gain products, sum and shift, clamp, and result queue.
`timescale 1ns / 1ps

module pcc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                empty_i,
  input  pcc_pkg::work_t                      word_i,
  output logic                                rd_o,
  input  pcc_pkg::cfg_t                       cfg_i,
  input  logic                                pop_i,
  output logic                                empty_o,
  output logic signed [pcc_pkg::DataWidth-1:0] drive_o
);

  logic signed [pcc_pkg::PropWidth-1:0] prod_p_d, prod_p_q;
  logic signed [pcc_pkg::IntgWidth-1:0] prod_i_d, prod_i_q;
  logic signed [pcc_pkg::DerWidth-1:0]  prod_d_d, prod_d_q;
  logic signed [pcc_pkg::AccWidth-1:0]  acc;
  logic signed [pcc_pkg::ShWidth-1:0]   sh_d, sh_q;
  logic signed [pcc_pkg::ShWidth-1:0]   lim_hi, lim_lo;
  logic signed [pcc_pkg::DataWidth-1:0] clamped;
  logic                                 v1_q, v2_q;
  logic [pcc_pkg::CreditWidth-1:0]      credit;
  logic                                 issue;

  logic signed [pcc_pkg::DataWidth-1:0] mem_q [pcc_pkg::OutDepth];
  logic [pcc_pkg::OutPtrWidth-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [pcc_pkg::OutCntWidth-1:0]      cnt_q, cnt_d;
  logic                                 rd;

  assign credit = pcc_pkg::CreditWidth'(cnt_q) + pcc_pkg::CreditWidth'(v1_q)
                + pcc_pkg::CreditWidth'(v2_q);
  assign issue  = !empty_i && (credit < pcc_pkg::CreditWidth'(pcc_pkg::OutDepth));
  assign rd_o   = issue;

  assign prod_p_d = cfg_i.gain_p * word_i.err;
  assign prod_i_d = cfg_i.gain_i * word_i.integ;
  assign prod_d_d = cfg_i.gain_d * word_i.deriv;

  always_comb begin
    acc = pcc_pkg::AccWidth'(prod_p_q) + pcc_pkg::AccWidth'(prod_i_q)
        + pcc_pkg::AccWidth'(prod_d_q);
    sh_d = acc[pcc_pkg::AccWidth-1:pcc_pkg::FracBits];
  end

  always_comb begin
    lim_hi = pcc_pkg::ShWidth'(cfg_i.out_max);
    lim_lo = pcc_pkg::ShWidth'(cfg_i.out_min);
    if (sh_q > lim_hi) begin
      clamped = cfg_i.out_max;
    end else if (sh_q < lim_lo) begin
      clamped = cfg_i.out_min;
    end else begin
      clamped = sh_q[pcc_pkg::DataWidth-1:0];
    end
  end

  assign rd      = pop_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign drive_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = v2_q ? pcc_pkg::OutPtrWidth'(wptr_q + 1'b1) : wptr_q;
    rptr_d = rd ? pcc_pkg::OutPtrWidth'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = cnt_q + pcc_pkg::OutCntWidth'(v2_q) - pcc_pkg::OutCntWidth'(rd);
  end

  always_ff @(posedge clk_i) begin
    prod_p_q <= prod_p_d;
    prod_i_q <= prod_i_d;
    prod_d_q <= prod_d_d;
    sh_q     <= sh_d;
    if (v2_q) begin
      mem_q[wptr_q] <= clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      v1_q   <= issue;
      v2_q   <= v1_q;
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> design/pid_controller_clamped_core.sv
// A pushed word passes the mid queue, the product and sum registers, and the result queue.
// Throughput: one word per cycle unless queues fill, set by the front-end integral update.
// The back end runs products, sum and clamp over two stages into a four-word result queue.
// Reset (asynchronous, active low) zeroes the integral, the previous sample, all
// configuration registers and empties both queues; there is no clearing pass.
`timescale 1ns / 1ps

module pid_controller_clamped_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [pcc_pkg::DataWidth-1:0]    measurement_i,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [pcc_pkg::DataWidth-1:0]    drive_o,
  input  logic                                    cfg_we_i,
  input  logic [pcc_pkg::CfgIdxWidth-1:0]         cfg_idx_i,
  input  logic [pcc_pkg::CfgDataWidth-1:0]        cfg_data_i
);

  pcc_pkg::cfg_t  cfg_q, cfg_d;
  pcc_pkg::work_t front_word, mid_word;
  logic           front_wr, mid_full, mid_empty, mid_rd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcc_pkg::RegSetpoint: cfg_d.setpoint = cfg_data_i[pcc_pkg::DataWidth-1:0];
        pcc_pkg::RegGainP:    cfg_d.gain_p   = cfg_data_i[pcc_pkg::GainWidth-1:0];
        pcc_pkg::RegGainI:    cfg_d.gain_i   = cfg_data_i[pcc_pkg::GainWidth-1:0];
        pcc_pkg::RegGainD:    cfg_d.gain_d   = cfg_data_i[pcc_pkg::GainWidth-1:0];
        pcc_pkg::RegOutMin:   cfg_d.out_min  = cfg_data_i[pcc_pkg::DataWidth-1:0];
        pcc_pkg::RegOutMax:   cfg_d.out_max  = cfg_data_i[pcc_pkg::DataWidth-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full = mid_full;

  pcc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .measurement_i (measurement_i),
    .setpoint_i    (cfg_q.setpoint),
    .q_full_i      (mid_full),
    .wr_o          (front_wr),
    .word_o        (front_word)
  );

  pcc_mid_q u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (front_wr),
    .wdata_i (front_word),
    .full_o  (mid_full),
    .rd_i    (mid_rd),
    .empty_o (mid_empty),
    .rdata_o (mid_word)
  );

  pcc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (mid_empty),
    .word_i  (mid_word),
    .rd_o    (mid_rd),
    .cfg_i   (cfg_q),
    .pop_i   (pop),
    .empty_o (empty),
    .drive_o (drive_o)
  );

endmodule

>>> design/pcc_checker.sv
// Port-level checker for the clamped PID controller, bound to the top level.
`timescale 1ns / 1ps

module pcc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             push,
  input logic                             full,
  input logic                             empty,
  input logic                             pop,
  input logic [pcc_pkg::DataWidth-1:0]    drive_o
);

  localparam int PendWidth = 4;

  logic [PendWidth-1:0] pend_q, pend_d;
  logic                 in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_comb begin
    pend_d = pend_q + PendWidth'(in_acc) - PendWidth'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("queues not idle after reset");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(drive_o)))
    else $error("waiting result word changed or vanished");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != '0))
    else $error("result word shown with nothing pending");

  a_full_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (pend_q >= PendWidth'(pcc_pkg::MidDepth)))
    else $error("full with too few words pending");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendWidth'(pcc_pkg::MidDepth + 2 + pcc_pkg::OutDepth))
    else $error("more words pending than storage holds");

endmodule

bind pid_controller_clamped_core pcc_checker u_pcc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .push    (push),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .drive_o (drive_o)
);

>>> test/pid_controller_clamped_core_tb.sv
// Self-checking testbench of the clamped PID controller core: queued stimulus, predicted drive.
`timescale 1ns / 1ps

module pid_controller_clamped_core_tb;

  localparam logic [pcc_pkg::CfgIdxWidth-1:0] RegSpareLo = 3'd6;
  localparam logic [pcc_pkg::CfgIdxWidth-1:0] RegSpareHi = 3'd7;
  localparam longint DataMax = (64'sd1 <<< (pcc_pkg::DataWidth - 1)) - 1;
  localparam longint DataMin = -DataMax - 1;
  localparam longint IntMax  = (64'sd1 <<< (pcc_pkg::IntWidth - 1)) - 1;
  localparam longint IntMin  = -IntMax - 1;
  localparam int     Phases  = 10;
  localparam int     PhaseLen = 124;

  logic                                   clk_i         = 1'b0;
  logic                                   rst_ni        = 1'b0;
  logic                                   push          = 1'b0;
  logic                                   full;
  logic signed [pcc_pkg::DataWidth-1:0]   measurement_i = '0;
  logic                                   empty;
  logic                                   pop           = 1'b0;
  logic signed [pcc_pkg::DataWidth-1:0]   drive_o;
  logic                                   cfg_we_i      = 1'b0;
  logic [pcc_pkg::CfgIdxWidth-1:0]        cfg_idx_i     = '0;
  logic [pcc_pkg::CfgDataWidth-1:0]       cfg_data_i    = '0;

  logic signed [pcc_pkg::DataWidth-1:0]   sp_r = '0;
  logic signed [pcc_pkg::GainWidth-1:0]   kp_r = '0;
  logic signed [pcc_pkg::GainWidth-1:0]   ki_r = '0;
  logic signed [pcc_pkg::GainWidth-1:0]   kd_r = '0;
  logic signed [pcc_pkg::DataWidth-1:0]   lo_r = '0;
  logic signed [pcc_pkg::DataWidth-1:0]   hi_r = '0;
  logic signed [pcc_pkg::IntWidth-1:0]    integ_sum = '0;
  logic signed [pcc_pkg::DataWidth-1:0]   prev_meas = '0;

  logic signed [pcc_pkg::DataWidth-1:0]   meas_q[$];
  logic signed [pcc_pkg::DataWidth-1:0]   drive_due_q[$];
  logic signed [pcc_pkg::DataWidth-1:0]   drive_due;
  bit                                     idle_on = 1'b0;
  int unsigned                            send_wait = 0;
  int unsigned                            recv_wait = 0;
  int unsigned                            miss_cnt = 0;

  pid_controller_clamped_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .measurement_i(measurement_i),
    .empty        (empty),
    .pop          (pop),
    .drive_o      (drive_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic signed [pcc_pkg::DataWidth-1:0] pid_drive(
    input logic signed [pcc_pkg::DataWidth-1:0] meas
  );
    longint err;
    longint der;
    longint sum;
    longint acc;
    longint val;
    err = longint'(sp_r) - longint'(meas);
    if (err > DataMax) err = DataMax;
    else if (err < DataMin) err = DataMin;
    der = longint'(meas) - longint'(prev_meas);
    sum = longint'(integ_sum) + err;
    if (sum > IntMax) sum = IntMax;
    else if (sum < IntMin) sum = IntMin;
    integ_sum = sum[pcc_pkg::IntWidth-1:0];
    acc = longint'(kp_r) * err + longint'(ki_r) * longint'(integ_sum)
        + longint'(kd_r) * der;
    val = acc >>> pcc_pkg::FracBits;
    prev_meas = meas;
    if (val > longint'(hi_r)) val = longint'(hi_r);
    else if (val < longint'(lo_r)) val = longint'(lo_r);
    return val[pcc_pkg::DataWidth-1:0];
  endfunction

  function automatic int unsigned draw_idle();
    return idle_on ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic logic [pcc_pkg::CfgDataWidth-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [pcc_pkg::CfgDataWidth-1:0] pick_gain();
    return ($urandom_range(0, 2) == 0) ? pick_value()
                                        : 16'($urandom_range(0, 1023)) - 16'd512;
  endfunction

  task automatic set_reg(input logic [pcc_pkg::CfgIdxWidth-1:0] idx,
                         input logic [pcc_pkg::CfgDataWidth-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      pcc_pkg::RegSetpoint: sp_r = val;
      pcc_pkg::RegGainP:    kp_r = val;
      pcc_pkg::RegGainI:    ki_r = val;
      pcc_pkg::RegGainD:    kd_r = val;
      pcc_pkg::RegOutMin:   lo_r = val;
      pcc_pkg::RegOutMax:   hi_r = val;
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (meas_q.size() != 0 || push || drive_due_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Sender: hold the word until accepted, then idle for the drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      send_wait <= 0;
    end else begin
      if (push && !full) drive_due_q.push_back(pid_drive(measurement_i));
      if (push && full) begin
      end else if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        push      <= 1'b0;
      end else if (meas_q.size() != 0) begin
        measurement_i <= meas_q.pop_front();
        push          <= 1'b1;
        send_wait     <= draw_idle();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: compare each popped word with the oldest predicted drive.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop       <= 1'b0;
      recv_wait = 0;
    end else if (pop && !empty) begin
      if (drive_due_q.size() == 0) begin
        if (miss_cnt < 10) $display("unexpected drive word %0d", drive_o);
        miss_cnt++;
      end else begin
        drive_due = drive_due_q.pop_front();
        if (drive_o !== drive_due) begin
          if (miss_cnt < 10) begin
            $display("drive mismatch: expected %0d, got %0d", drive_due, drive_o);
          end
          miss_cnt++;
        end
      end
      recv_wait = draw_idle();
      pop <= (recv_wait == 0);
    end else if (!pop) begin
      if (recv_wait != 0) recv_wait = recv_wait - 1;
      else pop <= 1'b1;
    end
  end

  initial begin : stim
    logic [pcc_pkg::CfgDataWidth-1:0] a;
    logic [pcc_pkg::CfgDataWidth-1:0] b;
    logic [pcc_pkg::DataWidth-1:0]    m;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: everything clamps to zero.
    meas_q.push_back(16'h7fff);
    meas_q.push_back(16'h8000);
    drain();

    set_reg(pcc_pkg::RegSetpoint, 16'h0000);
    set_reg(pcc_pkg::RegGainP, 16'h0100);
    set_reg(pcc_pkg::RegGainI, 16'h0000);
    set_reg(pcc_pkg::RegGainD, 16'h0000);
    set_reg(pcc_pkg::RegOutMin, 16'h8000);
    set_reg(pcc_pkg::RegOutMax, 16'h7fff);
    set_reg(RegSpareLo, 16'hffff);
    set_reg(RegSpareHi, 16'h1234);
    close_writes();
    meas_q.push_back(16'h0000);
    meas_q.push_back(16'h0001);
    meas_q.push_back(16'hffff);
    meas_q.push_back(16'h7fff);
    meas_q.push_back(16'h8000);
    meas_q.push_back(16'h5555);
    meas_q.push_back(16'haaaa);
    drain();

    // Error saturating low, then full-swing derivative with floor on both signs.
    set_reg(pcc_pkg::RegSetpoint, 16'h8000);
    close_writes();
    meas_q.push_back(16'h7fff);
    drain();
    set_reg(pcc_pkg::RegGainP, 16'h0000);
    set_reg(pcc_pkg::RegGainD, 16'h0001);
    close_writes();
    meas_q.push_back(16'h8000);
    meas_q.push_back(16'h7fff);
    meas_q.push_back(16'h8000);
    drain();

    // Inverted limits.
    set_reg(pcc_pkg::RegSetpoint, 16'h0000);
    set_reg(pcc_pkg::RegGainP, 16'h0100);
    set_reg(pcc_pkg::RegGainD, 16'h0000);
    set_reg(pcc_pkg::RegOutMin, 16'd100);
    set_reg(pcc_pkg::RegOutMax, -16'sd100);
    close_writes();
    meas_q.push_back(-16'sd500);
    meas_q.push_back(16'sd500);
    meas_q.push_back(16'sd0);
    drain();

    for (int ph = 0; ph < Phases; ph++) begin
      idle_on = (ph != 0) && ((ph == 1) || ($urandom_range(0, 3) != 0));
      if ($urandom_range(0, 3) != 0) set_reg(pcc_pkg::RegSetpoint, pick_value());
      if ($urandom_range(0, 3) != 0) set_reg(pcc_pkg::RegGainP, pick_gain());
      if ($urandom_range(0, 3) != 0) set_reg(pcc_pkg::RegGainI, pick_gain());
      if ($urandom_range(0, 3) != 0) set_reg(pcc_pkg::RegGainD, pick_gain());
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(0, 3))
        0: begin
          set_reg(pcc_pkg::RegOutMin, 16'h8000);
          set_reg(pcc_pkg::RegOutMax, 16'h7fff);
        end
        1: begin
          set_reg(pcc_pkg::RegOutMin, ($signed(a) < $signed(b)) ? a : b);
          set_reg(pcc_pkg::RegOutMax, ($signed(a) < $signed(b)) ? b : a);
        end
        2: begin
          set_reg(pcc_pkg::RegOutMin, ($signed(a) < $signed(b)) ? b : a);
          set_reg(pcc_pkg::RegOutMax, ($signed(a) < $signed(b)) ? a : b);
        end
        default: begin
          set_reg(pcc_pkg::RegOutMin, pick_value());
          set_reg(pcc_pkg::RegOutMax, pick_value());
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        set_reg($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, 16'($urandom));
      end
      close_writes();
      for (int i = 0; i < PhaseLen; i++) begin
        case ($urandom_range(0, 3))
          0: m = pick_value();
          1: m = sp_r + 16'($urandom_range(0, 255)) - 16'd128;
          default: m = 16'($urandom);
        endcase
        meas_q.push_back(m);
      end
      drain();
    end

    repeat (6) @(posedge clk_i);
    miss_cnt += drive_due_q.size();
    if (miss_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/pcc_pkg.sv
design/pcc_front.sv
design/pcc_mid_q.sv
design/pcc_back.sv
design/pid_controller_clamped_core.sv
design/pcc_checker.sv
test/pid_controller_clamped_core_tb.sv
